/* hdl/kpu_pkg.sv */
// Package for the permutation unranking block.
// Holds the shared item type, field widths and the factorial table.
// No dependencies.
`default_nettype none

package kpu_pkg;

    // Field widths fixed by the interface
    localparam int LEN_W   = 4;
    localparam int RANK_W  = 19;
    localparam int DIGIT_W = 4;

    // Largest length the factorial table covers
    localparam int LEN_LIMIT = 9;

    // Item carried down the division pipeline
    typedef struct packed {
        logic [LEN_W-1:0]  n;
        logic [RANK_W-1:0] r;
        logic              oor;
    } kpu_item_t;

    // Factorial of m for m in 0..9
    function automatic logic [RANK_W-1:0] fact_of(input logic [LEN_W-1:0] m);
        logic [RANK_W-1:0] f;
        begin
            case (m)
                4'd0:    f = 19'd1;
                4'd1:    f = 19'd1;
                4'd2:    f = 19'd2;
                4'd3:    f = 19'd6;
                4'd4:    f = 19'd24;
                4'd5:    f = 19'd120;
                4'd6:    f = 19'd720;
                4'd7:    f = 19'd5040;
                4'd8:    f = 19'd40320;
                default: f = 19'd362880;
            endcase
            return f;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/kpu_front.sv */
// Input stage: clamps the length, checks the rank against n! and forms
// the zero-based rank. Depends on kpu_pkg.
`default_nettype none

module kpu_front
    import kpu_pkg::*;
#(
    parameter int MAX_DIGITS = 9
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic [LEN_W-1:0]  length,
    input  wire logic [RANK_W-1:0] rank,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output kpu_item_t              out_item
);

    logic      valid_reg, valid_next;
    kpu_item_t item_reg, item_next;
    logic [LEN_W-1:0] n_clamp;
    logic             take;

    assign req_ready = !valid_reg || out_ready;
    assign take      = req_valid && req_ready;

    // Clamp length and check the rank range
    always_comb
    begin
        if (length > LEN_W'(MAX_DIGITS))
            n_clamp = LEN_W'(MAX_DIGITS);
        else if (length == '0)
            n_clamp = LEN_W'(1);
        else
            n_clamp = length;
        item_next.n   = n_clamp;
        item_next.oor = (rank == '0) || (rank > fact_of(n_clamp));
        item_next.r   = item_next.oor ? '0 : rank - RANK_W'(1);
    end

    // Advance the valid bit
    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold the payload until a new request is taken
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

/* hdl/kpu_div_stage.sv */
// One factoradic step: divides the remaining rank by WEIGHT! and stores
// the quotient as the Lehmer code entry of that weight. Depends on kpu_pkg.
`default_nettype none

module kpu_div_stage
    import kpu_pkg::*;
#(
    parameter int MAX_DIGITS = 9,
    parameter int WEIGHT     = 0
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire kpu_item_t                       in_item,
    input  wire logic [MAX_DIGITS*DIGIT_W-1:0]   in_codes,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output kpu_item_t                            out_item,
    output logic [MAX_DIGITS*DIGIT_W-1:0]        out_codes
);

    localparam logic [RANK_W:0] STEP = {1'b0, fact_of(LEN_W'(WEIGHT))};

    logic                              valid_reg, valid_next;
    kpu_item_t                         item_reg, item_next;
    logic [MAX_DIGITS*DIGIT_W-1:0]     codes_reg, codes_next;
    logic [DIGIT_W-1:0]                quot;
    logic [RANK_W:0]                   rem;
    logic                              take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Divide by the constant weight: compare against each multiple
    always_comb
    begin
        quot = '0;
        rem  = {1'b0, in_item.r};
        for (int q = 1; q <= WEIGHT; q++)
        begin
            if ({1'b0, in_item.r} >= (RANK_W+1)'(q) * STEP)
            begin
                quot = DIGIT_W'(q);
                rem  = {1'b0, in_item.r} - (RANK_W+1)'(q) * STEP;
            end
        end
        item_next     = in_item;
        item_next.r   = rem[RANK_W-1:0];
        codes_next    = in_codes;
        codes_next[WEIGHT*DIGIT_W +: DIGIT_W] = quot;
    end

    // Advance the valid bit
    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg  <= item_next;
            codes_reg <= codes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_codes = codes_reg;

endmodule

`default_nettype wire

/* hdl/kpu_serializer.sv */
// Turns a Lehmer code into digits, one per cycle unless results stall, picking
// from the pool of unused digits and closing the gap. Depends on kpu_pkg.
`default_nettype none

module kpu_serializer
    import kpu_pkg::*;
#(
    parameter int MAX_DIGITS = 9
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire kpu_item_t                       in_item,
    input  wire logic [MAX_DIGITS*DIGIT_W-1:0]   in_codes,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output logic [DIGIT_W-1:0]                   digit,
    output logic                                 last,
    output logic                                 out_of_range
);

    localparam int JW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic                          busy_reg, busy_next;
    logic                          oor_reg, oor_next;
    logic [JW-1:0]                 j_reg, j_next;
    logic [MAX_DIGITS*DIGIT_W-1:0] codes_reg, codes_next;
    logic [DIGIT_W-1:0]            pool_reg [MAX_DIGITS];
    logic [DIGIT_W-1:0]            pool_next [MAX_DIGITS];
    logic                          res_valid_reg, res_valid_next;
    logic [DIGIT_W-1:0]            digit_reg, digit_next;
    logic                          last_reg, last_next;
    logic                          oor_out_reg, oor_out_next;
    logic                          emit, last_now, take;
    logic [DIGIT_W-1:0]            idx, pick;

    assign emit     = busy_reg && (!res_valid_reg || res_ready);
    assign last_now = oor_reg || (j_reg == '0);
    assign in_ready = !busy_reg || (emit && last_now);
    assign take     = in_valid && in_ready;

    // Select the code entry at the current weight and the pool digit
    always_comb
    begin
        idx  = '0;
        pick = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (j_reg == JW'(i))
                idx = codes_reg[i*DIGIT_W +: DIGIT_W];
        end
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (idx == DIGIT_W'(i))
                pick = pool_reg[i];
        end
    end

    // Sequence the digits and load the next request
    always_comb
    begin
        busy_next      = busy_reg;
        oor_next       = oor_reg;
        j_next         = j_reg;
        codes_next     = codes_reg;
        pool_next      = pool_reg;
        res_valid_next = res_valid_reg;
        digit_next     = digit_reg;
        last_next      = last_reg;
        oor_out_next   = oor_out_reg;

        // Drop a taken result
        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        // Emit one digit and close the gap in the pool
        if (emit)
        begin
            res_valid_next = 1'b1;
            digit_next     = oor_reg ? '0 : pick;
            last_next      = last_now;
            oor_out_next   = oor_reg;
            j_next         = j_reg - JW'(1);
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                if (DIGIT_W'(i) >= idx)
                    pool_next[i] = (i + 1 < MAX_DIGITS) ? pool_reg[(i + 1) % MAX_DIGITS]
                                                        : '0;
            end
            if (last_now)
                busy_next = 1'b0;
        end

        // Load a new request with a fresh pool
        if (take)
        begin
            busy_next  = 1'b1;
            oor_next   = in_item.oor;
            j_next     = JW'(in_item.n - LEN_W'(1));
            codes_next = in_codes;
            for (int i = 0; i < MAX_DIGITS; i++)
                pool_next[i] = DIGIT_W'(i + 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oor_reg     <= oor_next;
        j_reg       <= j_next;
        codes_reg   <= codes_next;
        pool_reg    <= pool_next;
        digit_reg   <= digit_next;
        last_reg    <= last_next;
        oor_out_reg <= oor_out_next;
    end

    assign res_valid    = res_valid_reg;
    assign digit        = digit_reg;
    assign last         = last_reg;
    assign out_of_range = oor_out_reg;

    // A Lehmer entry never exceeds its weight
    a_code_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !oor_reg |-> idx <= DIGIT_W'(j_reg))
        else $error("Lehmer code entry exceeds its weight");

    // Out-of-range results are a single zero digit
    a_oor_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && oor_out_reg |-> last_reg && digit_reg == '0)
        else $error("out-of-range result is not a lone zero digit");

    // Normal digits lie in 1..MAX_DIGITS
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !oor_out_reg |->
            digit_reg != '0 && digit_reg <= DIGIT_W'(MAX_DIGITS))
        else $error("digit outside 1..MAX_DIGITS");

endmodule

`default_nettype wire

/* hdl/kth_permutation_unrank.sv */
// Top level of the lexicographic permutation unranking block.
// Depends on kpu_pkg, kpu_front, kpu_div_stage and kpu_serializer.
//
//   channel  | direction | signals                          | payload
//   request  | in        | req_valid / req_ready            | length, rank
//   result   | out       | res_valid / res_ready            | digit, last, out_of_range
//
// A request passes the input stage and MAX_DIGITS division stages, and a
// new request may enter every cycle while the chain is not stalled. The
// serializer then emits n results, one per cycle while results are taken
// (one result when out of range), so it bounds the sustained request rate.
// Reset clears all valid bits. Back-pressure on results stalls the chain
// stage by stage; nothing is dropped or repeated.
`default_nettype none

module kth_permutation_unrank
    import kpu_pkg::*;
#(
    parameter int MAX_DIGITS = 9
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic [LEN_W-1:0]  length,
    input  wire logic [RANK_W-1:0] rank,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic [DIGIT_W-1:0]     digit,
    output logic                   last,
    output logic                   out_of_range
);

    localparam int CODES_W = MAX_DIGITS * DIGIT_W;

    logic [MAX_DIGITS:0] stg_valid;
    logic [MAX_DIGITS:0] stg_ready;
    kpu_item_t           stg_item  [MAX_DIGITS+1];
    logic [CODES_W-1:0]  stg_codes [MAX_DIGITS+1];

    // Clamp and range-check the request
    kpu_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .length    (length),
        .rank      (rank),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_item  (stg_item[0])
    );

    assign stg_codes[0] = '0;

    // Division stages, highest weight first
    for (genvar g = 0; g < MAX_DIGITS; g++)
    begin : g_div
        kpu_div_stage #(
            .MAX_DIGITS (MAX_DIGITS),
            .WEIGHT     (MAX_DIGITS - 1 - g)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_item   (stg_item[g]),
            .in_codes  (stg_codes[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_item  (stg_item[g+1]),
            .out_codes (stg_codes[g+1])
        );
    end

    // Emit the digits
    kpu_serializer #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (stg_valid[MAX_DIGITS]),
        .in_ready     (stg_ready[MAX_DIGITS]),
        .in_item      (stg_item[MAX_DIGITS]),
        .in_codes     (stg_codes[MAX_DIGITS]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .digit        (digit),
        .last         (last),
        .out_of_range (out_of_range)
    );

endmodule

`default_nettype wire

/* verif/tb_kth_permutation_unrank.sv */
// Testbench for kth_permutation_unrank: directed table plus random requests, every result checked
// against the table's typed digits or an in-bench unranking predictor.
// Depends on kpu_pkg and the kth_permutation_unrank RTL.

module tb_kth_permutation_unrank
    import kpu_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 410;
    localparam int QUIET_FROM      = 350;
    localparam int HOLD_AT         = 150;
    localparam int PAUSE_AT        = 300;
    localparam int HOLD_CYCLES     = 80;
    localparam int DRAIN_CYCLES    = 40;
    localparam logic [RANK_W-1:0] RANK_MAX = '1;

    // One expected result
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic               oor;
    } perm_digit_t;

    // One directed request; typed rows carry their digits as hex nibbles
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [RANK_W-1:0] rank;
        bit                typed;
        logic [3:0]        cnt;
        logic [35:0]       digs;
        bit                oor;
    } request_row_t;

    localparam int DIRECTED_ROWS = 20;

    request_row_t directed_rows [DIRECTED_ROWS] = '{
        '{4'd1,  19'd1,      1'b1, 4'd1, 36'h000000001, 1'b0},
        '{4'd0,  19'd1,      1'b1, 4'd1, 36'h000000001, 1'b0},
        '{4'd0,  19'd2,      1'b1, 4'd1, 36'h000000000, 1'b1},
        '{4'd9,  19'd1,      1'b1, 4'd9, 36'h123456789, 1'b0},
        '{4'd9,  19'd362880, 1'b1, 4'd9, 36'h987654321, 1'b0},
        '{4'd9,  19'd362881, 1'b1, 4'd1, 36'h000000000, 1'b1},
        '{4'd15, 19'd1,      1'b1, 4'd9, 36'h123456789, 1'b0},
        '{4'd15, 19'd362880, 1'b1, 4'd9, 36'h987654321, 1'b0},
        '{4'd3,  19'd0,      1'b1, 4'd1, 36'h000000000, 1'b1},
        '{4'd4,  19'd25,     1'b1, 4'd1, 36'h000000000, 1'b1},
        '{4'd4,  19'd24,     1'b1, 4'd4, 36'h000004321, 1'b0},
        '{4'd2,  19'd2,      1'b1, 4'd2, 36'h000000021, 1'b0},
        '{4'd3,  19'd4,      1'b0, 4'd0, 36'h0,         1'b0},
        '{4'd9,  RANK_MAX,   1'b1, 4'd1, 36'h000000000, 1'b1},
        '{4'd5,  19'd60,     1'b0, 4'd0, 36'h0,         1'b0},
        '{4'd8,  19'd40320,  1'b1, 4'd8, 36'h087654321, 1'b0},
        '{4'd8,  19'd40321,  1'b1, 4'd1, 36'h000000000, 1'b1},
        '{4'd10, 19'd100000, 1'b0, 4'd0, 36'h0,         1'b0},
        '{4'd7,  19'd2500,   1'b0, 4'd0, 36'h0,         1'b0},
        '{4'd6,  19'd721,    1'b1, 4'd1, 36'h000000000, 1'b1}
    };

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    logic [LEN_W-1:0]   length;
    logic [RANK_W-1:0]  rank;
    logic               res_valid;
    logic               res_ready;
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               out_of_range;

    perm_digit_t pending_digits [$];
    int          mismatches = 0;
    bit          quiet_run = 1'b0;
    bit          hold_results = 1'b0;

    kth_permutation_unrank dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .length       (length),
        .rank         (rank),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .digit        (digit),
        .last         (last),
        .out_of_range (out_of_range)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Number of permutations of m digits
    function automatic int unsigned perm_count(input int unsigned m);
        int unsigned f;
        f = 1;
        for (int unsigned i = 2; i <= m; i++)
        begin
            f *= i;
        end
        return f;
    endfunction

    // Append one expected result at the tail of the queue
    function automatic void queue_digit(input perm_digit_t d);
        pending_digits.insert(pending_digits.size(), d);
    endfunction

    // Unrank one request in the factorial number system, queue its digits
    function automatic void unrank_expected(input logic [LEN_W-1:0] len_in,
                                            input logic [RANK_W-1:0] rank_in);
        logic [DIGIT_W-1:0] pool [LEN_LIMIT];
        int unsigned        n;
        int unsigned        r;
        int unsigned        m;
        int unsigned        f;
        int unsigned        idx;
        perm_digit_t        d;
        n = len_in;
        if (n > LEN_LIMIT)
        begin
            n = LEN_LIMIT;
        end
        if (n == 0)
        begin
            n = 1;
        end
        if (rank_in == 0 || rank_in > perm_count(n))
        begin
            d.digit = '0;
            d.last  = 1'b1;
            d.oor   = 1'b1;
            queue_digit(d);
            return;
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            pool[i] = DIGIT_W'(i + 1);
        end
        r = rank_in - 1;
        for (int unsigned pos = 0; pos < n; pos++)
        begin
            m   = n - pos;
            f   = perm_count(m - 1);
            idx = r / f;
            r   = r % f;
            if (idx >= m)
            begin
                idx = m - 1;
            end
            d.digit = pool[idx];
            d.last  = (pos + 1 == n);
            d.oor   = 1'b0;
            queue_digit(d);
            // drop the used digit from the pool
            for (int unsigned i = idx; i + 1 < m; i++)
            begin
                pool[i] = pool[i + 1];
            end
        end
    endfunction

    // Offer one request, hold it until accepted, then queue its digits
    task automatic offer_request(input logic [LEN_W-1:0] len_v,
                                 input logic [RANK_W-1:0] rank_v,
                                 input bit typed,
                                 input logic [3:0] cnt,
                                 input logic [35:0] digs,
                                 input bit oor);
        perm_digit_t d;
        if (!quiet_run && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        length    <= len_v;
        rank      <= rank_v;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        if (typed)
        begin
            for (int i = 0; i < cnt; i++)
            begin
                d.digit = digs[4*(cnt-1-i) +: 4];
                d.last  = (i == cnt - 1);
                d.oor   = oor;
                queue_digit(d);
            end
        end
        else
        begin
            unrank_expected(len_v, rank_v);
        end
    endtask

    // Result sink: short random stalls, one long hold-off on request
    initial
    begin
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_ready <= 1'b1;
                hold_results = 1'b0;
            end
            else if (!quiet_run && $urandom_range(0, 5) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                res_ready <= 1'b1;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expected digit
    always @(posedge clk)
    begin : check_results
        perm_digit_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_digits.size() == 0)
            begin
                $error("unexpected result: digit %0d last %0b out_of_range %0b",
                       digit, last, out_of_range);
                mismatches++;
            end
            else
            begin
                want = pending_digits.pop_front();
                if (digit !== want.digit)
                begin
                    $error("digit: expected %0d, got %0d", want.digit, digit);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    mismatches++;
                end
                if (out_of_range !== want.oor)
                begin
                    $error("out_of_range: expected %0b, got %0b", want.oor, out_of_range);
                    mismatches++;
                end
            end
        end
    end

    // Request source: directed table, then random requests
    initial
    begin
        logic [LEN_W-1:0]  len_v;
        logic [RANK_W-1:0] rank_v;
        int unsigned       n_eff;
        int unsigned       kind;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        length    <= '0;
        rank      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_request(directed_rows[i].len, directed_rows[i].rank,
                          directed_rows[i].typed, directed_rows[i].cnt,
                          directed_rows[i].digs, directed_rows[i].oor);
        end

        for (int idx = 0; idx < RANDOM_REQUESTS; idx++)
        begin
            if (idx == HOLD_AT)
            begin
                hold_results = 1'b1;
            end
            if (idx == PAUSE_AT)
            begin
                // drain everything before offering more
                req_valid <= 1'b0;
                while (pending_digits.size() != 0)
                begin
                    @(posedge clk);
                end
                @(posedge clk);
            end
            if (idx >= QUIET_FROM)
            begin
                quiet_run = 1'b1;
            end
            kind  = $urandom_range(0, 19);
            n_eff = $urandom_range(1, LEN_LIMIT);
            len_v = LEN_W'(n_eff);
            if (kind == 0)
            begin
                // length outside 1..9, any rank
                len_v  = ($urandom_range(0, 5) == 0) ? '0 : LEN_W'($urandom_range(10, 15));
                rank_v = RANK_W'($urandom_range(0, RANK_MAX));
            end
            else if (kind == 1)
            begin
                rank_v = '0;
            end
            else if (kind == 2)
            begin
                rank_v = RANK_W'($urandom_range(RANK_MAX, perm_count(n_eff) + 1));
            end
            else if (kind == 3)
            begin
                rank_v = ($urandom_range(0, 1) == 0) ? RANK_W'(1) : RANK_W'(perm_count(n_eff));
            end
            else
            begin
                rank_v = RANK_W'($urandom_range(perm_count(n_eff), 1));
            end
            offer_request(len_v, rank_v, 1'b0, '0, '0, 1'b0);
        end
        req_valid <= 1'b0;

        while (pending_digits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #4ms;
        $display("FAIL");
        $finish;
    end

endmodule
